// ===== hdl/drfp_pkg.sv =====
package drfp_pkg;

   localparam int unsigned CSR_INDEX_W = 3;

   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_TICK    = 2'd1,
      OP_NUM_REQ = 2'd2,
      OP_TXT_REQ = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_NUMBER   = 3'd0,
      KIND_CHAR     = 3'd1,
      KIND_DONE     = 3'd2,
      KIND_PAGE     = 3'd3,
      KIND_CUSTOM   = 3'd4,
      KIND_TIMEOUT  = 3'd5,
      KIND_FRAMING  = 3'd6,
      KIND_OVERFLOW = 3'd7
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REPLY_TIMEOUT = 3'd0,
      CSR_LEAD_TIMEOUT  = 3'd1,
      CSR_BODY_TIMEOUT  = 3'd2,
      CSR_MAX_TEXT      = 3'd3,
      CSR_FAILURE_VALUE = 3'd4
   } csr_index_type;

   typedef enum logic [10:0] {
      PH_IDLE       = 11'b000_0000_0001,
      PH_HASH_LEN   = 11'b000_0000_0010,
      PH_HASH_CMD   = 11'b000_0000_0100,
      PH_HASH_PAGE  = 11'b000_0000_1000,
      PH_NUM_WAIT   = 11'b000_0001_0000,
      PH_NUM_SEARCH = 11'b000_0010_0000,
      PH_NUM_DATA   = 11'b000_0100_0000,
      PH_NUM_TERM   = 11'b000_1000_0000,
      PH_TXT_WAIT   = 11'b001_0000_0000,
      PH_TXT_SEARCH = 11'b010_0000_0000,
      PH_TXT_BODY   = 11'b100_0000_0000
   } phase_type;

   localparam logic [7:0] NUM_LEAD  = 8'h71;
   localparam logic [7:0] TXT_LEAD  = 8'h70;
   localparam logic [7:0] TERM_BYTE = 8'hFF;
   localparam logic [7:0] HASH_BYTE = 8'h23;
   localparam logic [7:0] PAGE_CMD  = 8'h50;

   localparam logic [15:0] REPLY_TIMEOUT_RESET = 16'd400;
   localparam logic [15:0] LEAD_TIMEOUT_RESET  = 16'd100;
   localparam logic [15:0] BODY_TIMEOUT_RESET  = 16'd1000;
   localparam logic [7:0]  MAX_TEXT_RESET      = 8'd255;
   localparam logic [31:0] FAILURE_VALUE_RESET = 32'd777777;

   typedef struct packed {
      op_type     operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [31:0] number_value;
      logic [7:0]  text_char;
      logic [7:0]  page_id;
      logic [7:0]  previous_page;
      logic [7:0]  command_group;
      logic [7:0]  command_length;
   } rsp_type;

   typedef struct packed {
      logic [15:0] reply_timeout;
      logic [15:0] lead_timeout;
      logic [15:0] body_timeout;
      logic [7:0]  max_text_length;
      logic [31:0] failure_value;
   } cfg_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] rx_byte;
      logic       is_num_lead;
      logic       is_txt_lead;
      logic       is_term;
      logic       is_hash;
      logic       is_page;
   } cmd_type;

endpackage

// ===== hdl/display_reply_frame_parser.sv =====
// A result is registered into the result queue by the transfer of the item causing it.
// Throughput: one item per cycle while the result queue has room; the engine stalls when it is full.
// A two-entry command queue and a two-entry result queue decouple both sides.
// Reset (synchronous): queues empty, parser idle, counters and page ids zero,
// registers back to their defaults.
module display_reply_frame_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  drfp_pkg::req_type                   req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output drfp_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [drfp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                         csr_wdata
);
   import drfp_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_take;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_REPLY_TIMEOUT: cfg_in.reply_timeout   = csr_wdata[15:0];
            CSR_LEAD_TIMEOUT:  cfg_in.lead_timeout    = csr_wdata[15:0];
            CSR_BODY_TIMEOUT:  cfg_in.body_timeout    = csr_wdata[15:0];
            CSR_MAX_TEXT:      cfg_in.max_text_length = csr_wdata[7:0];
            CSR_FAILURE_VALUE: cfg_in.failure_value   = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reply_timeout   <= REPLY_TIMEOUT_RESET;
         cfg_ff.lead_timeout    <= LEAD_TIMEOUT_RESET;
         cfg_ff.body_timeout    <= BODY_TIMEOUT_RESET;
         cfg_ff.max_text_length <= MAX_TEXT_RESET;
         cfg_ff.failure_value   <= FAILURE_VALUE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   drfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd)
   );

   drfp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      req_full && !cmd_take |=> req_full)
      else $error("command queue drained without an engine transfer");

   a_fail_value: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_data.result_kind == KIND_TIMEOUT ||
                     rsp_data.result_kind == KIND_FRAMING)
      |-> rsp_data.number_value == cfg_ff.failure_value)
      else $error("failed reply without the failure value");

   a_char_fields: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.result_kind == KIND_CHAR
      |-> rsp_data.number_value == 32'd0 && rsp_data.page_id == 8'd0 &&
          rsp_data.previous_page == 8'd0 && rsp_data.command_group == 8'd0 &&
          rsp_data.command_length == 8'd0)
      else $error("text character carries stray fields");
`endif

endmodule

// ===== hdl/drfp_front.sv =====
module drfp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  drfp_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output drfp_pkg::cmd_type cmd
);
   import drfp_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    class_cmd;
   logic       push;
   logic       pop;

   always_comb begin
      class_cmd.operation   = req_data.operation;
      class_cmd.rx_byte     = req_data.rx_byte;
      class_cmd.is_num_lead = (req_data.rx_byte == NUM_LEAD);
      class_cmd.is_txt_lead = (req_data.rx_byte == TXT_LEAD);
      class_cmd.is_term     = (req_data.rx_byte == TERM_BYTE);
      class_cmd.is_hash     = (req_data.rx_byte == HASH_BYTE);
      class_cmd.is_page     = (req_data.rx_byte == PAGE_CMD);
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign push      = req_push && !req_full;
   assign pop       = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= class_cmd;
      end
   end

endmodule

// ===== hdl/drfp_engine.sv =====
module drfp_engine (
   input  logic              clock,
   input  logic              reset,
   input  drfp_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  drfp_pkg::cmd_type cmd,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output drfp_pkg::rsp_type rsp_data
);
   import drfp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;
   logic [1:0]  term_cnt_ff, term_cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [7:0]  text_cnt_ff, text_cnt_in;
   logic [7:0]  cur_page_ff, cur_page_in;
   logic [7:0]  last_page_ff, last_page_in;
   logic [7:0]  frame_len_ff, frame_len_in;

   rsp_type     rq_ff [2];
   logic        rq_wr_ff, rq_wr_in;
   logic        rq_rd_ff, rq_rd_in;
   logic [1:0]  rq_count_ff, rq_count_in;

   rsp_type     res;
   logic        res_valid;
   logic [15:0] limit;
   logic        timed;
   logic        is_request;
   logic        rq_push;
   logic        rq_pop;

   assign cmd_take = cmd_valid && (rq_count_ff != 2'd2);

   always_comb begin
      limit      = cfg.lead_timeout;
      timed      = 1'b0;
      is_request = 1'b0;
      unique case (phase_ff)
         PH_HASH_LEN, PH_HASH_CMD, PH_HASH_PAGE: begin
            limit = cfg.lead_timeout;
            timed = 1'b1;
         end
         PH_NUM_WAIT, PH_TXT_WAIT: begin
            limit      = cfg.reply_timeout;
            timed      = 1'b1;
            is_request = 1'b1;
         end
         PH_NUM_SEARCH, PH_TXT_SEARCH: begin
            limit      = cfg.lead_timeout;
            timed      = 1'b1;
            is_request = 1'b1;
         end
         PH_NUM_DATA, PH_NUM_TERM, PH_TXT_BODY: begin
            limit      = cfg.body_timeout;
            timed      = 1'b1;
            is_request = 1'b1;
         end
         default: begin
            timed = 1'b0;
         end
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      byte_idx_in  = byte_idx_ff;
      term_cnt_in  = term_cnt_ff;
      acc_in       = acc_ff;
      elapsed_in   = elapsed_ff;
      text_cnt_in  = text_cnt_ff;
      cur_page_in  = cur_page_ff;
      last_page_in = last_page_ff;
      frame_len_in = frame_len_ff;
      res          = '0;
      res_valid    = 1'b0;
      unique case (cmd.operation)
         OP_NUM_REQ, OP_TXT_REQ: begin
            byte_idx_in = 2'd0;
            term_cnt_in = 2'd0;
            acc_in      = 32'd0;
            text_cnt_in = 8'd0;
            elapsed_in  = 16'd0;
            phase_in    = (cmd.operation == OP_NUM_REQ) ? PH_NUM_WAIT : PH_TXT_WAIT;
         end
         OP_TICK: begin
            if (timed) begin
               if (elapsed_ff < limit) begin
                  elapsed_in = elapsed_ff + 16'd1;
               end else begin
                  phase_in   = PH_IDLE;
                  elapsed_in = 16'd0;
                  if (is_request) begin
                     res_valid          = 1'b1;
                     res.result_kind    = KIND_TIMEOUT;
                     res.number_value   = cfg.failure_value;
                  end
               end
            end
         end
         default: begin
            unique case (phase_ff)
               PH_HASH_LEN: begin
                  frame_len_in = cmd.rx_byte;
                  phase_in     = PH_HASH_CMD;
                  elapsed_in   = 16'd0;
               end
               PH_HASH_CMD: begin
                  elapsed_in = 16'd0;
                  if (cmd.is_page) begin
                     last_page_in = cur_page_ff;
                     phase_in     = PH_HASH_PAGE;
                  end else begin
                     phase_in           = PH_IDLE;
                     res_valid          = 1'b1;
                     res.result_kind    = KIND_CUSTOM;
                     res.command_group  = cmd.rx_byte;
                     res.command_length = frame_len_ff;
                  end
               end
               PH_HASH_PAGE: begin
                  cur_page_in       = cmd.rx_byte;
                  phase_in          = PH_IDLE;
                  elapsed_in        = 16'd0;
                  res_valid         = 1'b1;
                  res.result_kind   = KIND_PAGE;
                  res.page_id       = cmd.rx_byte;
                  res.previous_page = last_page_ff;
               end
               PH_NUM_WAIT, PH_NUM_SEARCH: begin
                  if (cmd.is_num_lead) begin
                     phase_in   = PH_NUM_DATA;
                     elapsed_in = 16'd0;
                  end else if (phase_ff == PH_NUM_WAIT) begin
                     phase_in   = PH_NUM_SEARCH;
                     elapsed_in = 16'd0;
                  end
               end
               PH_NUM_DATA: begin
                  acc_in     = acc_ff | ({24'd0, cmd.rx_byte} << {byte_idx_ff, 3'b000});
                  elapsed_in = 16'd0;
                  if (byte_idx_ff == 2'd3) begin
                     byte_idx_in = 2'd0;
                     term_cnt_in = 2'd0;
                     phase_in    = PH_NUM_TERM;
                  end else begin
                     byte_idx_in = byte_idx_ff + 2'd1;
                  end
               end
               PH_NUM_TERM: begin
                  elapsed_in = 16'd0;
                  if (!cmd.is_term) begin
                     phase_in         = PH_IDLE;
                     res_valid        = 1'b1;
                     res.result_kind  = KIND_FRAMING;
                     res.number_value = cfg.failure_value;
                  end else if (term_cnt_ff >= 2'd2) begin
                     phase_in         = PH_IDLE;
                     res_valid        = 1'b1;
                     res.result_kind  = KIND_NUMBER;
                     res.number_value = acc_ff;
                  end else begin
                     term_cnt_in = term_cnt_ff + 2'd1;
                  end
               end
               PH_TXT_WAIT, PH_TXT_SEARCH: begin
                  if (cmd.is_txt_lead) begin
                     phase_in   = PH_TXT_BODY;
                     elapsed_in = 16'd0;
                  end else if (phase_ff == PH_TXT_WAIT) begin
                     phase_in   = PH_TXT_SEARCH;
                     elapsed_in = 16'd0;
                  end
               end
               PH_TXT_BODY: begin
                  elapsed_in = 16'd0;
                  if (cmd.is_term) begin
                     if (term_cnt_ff >= 2'd2) begin
                        phase_in        = PH_IDLE;
                        res_valid       = 1'b1;
                        res.result_kind = KIND_DONE;
                     end else begin
                        term_cnt_in = term_cnt_ff + 2'd1;
                     end
                  end else begin
                     term_cnt_in = 2'd0;
                     if (text_cnt_ff >= cfg.max_text_length) begin
                        phase_in        = PH_IDLE;
                        res_valid       = 1'b1;
                        res.result_kind = KIND_OVERFLOW;
                     end else begin
                        text_cnt_in     = text_cnt_ff + 8'd1;
                        res_valid       = 1'b1;
                        res.result_kind = KIND_CHAR;
                        res.text_char   = cmd.rx_byte;
                     end
                  end
               end
               default: begin
                  if (cmd.is_hash) begin
                     phase_in   = PH_HASH_LEN;
                     elapsed_in = 16'd0;
                  end
               end
            endcase
         end
      endcase
   end

   // result queue
   assign rq_push   = cmd_take && res_valid;
   assign rq_pop    = rsp_pop && !rsp_empty;
   assign rsp_empty = (rq_count_ff == 2'd0);
   assign rsp_data  = rq_ff[rq_rd_ff];

   always_comb begin
      rq_wr_in    = rq_push ? !rq_wr_ff : rq_wr_ff;
      rq_rd_in    = rq_pop ? !rq_rd_ff : rq_rd_ff;
      rq_count_in = rq_count_ff + {1'b0, rq_push} - {1'b0, rq_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         byte_idx_ff  <= 2'd0;
         term_cnt_ff  <= 2'd0;
         acc_ff       <= 32'd0;
         elapsed_ff   <= 16'd0;
         text_cnt_ff  <= 8'd0;
         cur_page_ff  <= 8'd0;
         last_page_ff <= 8'd0;
         frame_len_ff <= 8'd0;
         rq_wr_ff     <= 1'b0;
         rq_rd_ff     <= 1'b0;
         rq_count_ff  <= 2'd0;
      end else begin
         if (cmd_take) begin
            phase_ff     <= phase_in;
            byte_idx_ff  <= byte_idx_in;
            term_cnt_ff  <= term_cnt_in;
            acc_ff       <= acc_in;
            elapsed_ff   <= elapsed_in;
            text_cnt_ff  <= text_cnt_in;
            cur_page_ff  <= cur_page_in;
            last_page_ff <= last_page_in;
            frame_len_ff <= frame_len_in;
         end
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_ff[rq_wr_ff] <= res;
      end
   end

endmodule

// ===== dv/tb_display_reply_frame_parser.sv =====
module tb_display_reply_frame_parser;
   timeunit 1ns;
   timeprecision 1ps;
   import drfp_pkg::*;

   // Mirror of the deframer: register copy, parse state and the results still owed.
   class drfp_book;
      cfg_type     regs;
      phase_type   phase;
      logic [1:0]  byte_idx;
      logic [1:0]  term_cnt;
      logic [31:0] acc;
      logic [15:0] ticks;
      logic [7:0]  chars;
      logic [7:0]  page_now;
      logic [7:0]  page_prev;
      logic [7:0]  frame_len;
      logic [7:0]  frame_cmd;
      rsp_type     replies[$];
      int          errors;

      function new();
         regs = '{REPLY_TIMEOUT_RESET, LEAD_TIMEOUT_RESET, BODY_TIMEOUT_RESET,
                  MAX_TEXT_RESET, FAILURE_VALUE_RESET};
         phase     = PH_IDLE;
         byte_idx  = '0;
         term_cnt  = '0;
         acc       = '0;
         ticks     = '0;
         chars     = '0;
         page_now  = '0;
         page_prev = '0;
         frame_len = '0;
         frame_cmd = '0;
         errors    = 0;
      endfunction

      task report(string what, logic [31:0] got_v, logic [31:0] want_v);
         errors++;
         if (errors <= 40) begin
            $display("mismatch: %s: got 0x%0h, expected 0x%0h", what, got_v, want_v);
         end
      endtask

      function void goto(phase_type p);
         phase = p;
         ticks = '0;
      endfunction

      function void open_reply(phase_type p);
         byte_idx = '0;
         term_cnt = '0;
         acc      = '0;
         chars    = '0;
         goto(p);
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_REPLY_TIMEOUT: regs.reply_timeout   = value[15:0];
            CSR_LEAD_TIMEOUT:  regs.lead_timeout    = value[15:0];
            CSR_BODY_TIMEOUT:  regs.body_timeout    = value[15:0];
            CSR_MAX_TEXT:      regs.max_text_length = value[7:0];
            CSR_FAILURE_VALUE: regs.failure_value   = value;
            default: ;
         endcase
      endfunction

      function void note_input(req_type r);
         rsp_type     o;
         logic [15:0] limit;
         logic [7:0]  b;
         bit          hit;
         bit          timed;
         bit          for_reply;
         o         = '0;
         hit       = 1'b0;
         timed     = 1'b1;
         for_reply = 1'b1;
         limit     = '0;
         b         = r.rx_byte;
         case (r.operation)
            OP_NUM_REQ: open_reply(PH_NUM_WAIT);
            OP_TXT_REQ: open_reply(PH_TXT_WAIT);
            OP_TICK: begin
               case (phase)
                  PH_HASH_LEN, PH_HASH_CMD, PH_HASH_PAGE: begin
                     limit     = regs.lead_timeout;
                     for_reply = 1'b0;
                  end
                  PH_NUM_WAIT, PH_TXT_WAIT:            limit = regs.reply_timeout;
                  PH_NUM_SEARCH, PH_TXT_SEARCH:        limit = regs.lead_timeout;
                  PH_NUM_DATA, PH_NUM_TERM, PH_TXT_BODY: limit = regs.body_timeout;
                  default: timed = 1'b0;
               endcase
               if (timed) begin
                  if (ticks < limit) begin
                     ticks = ticks + 16'd1;
                  end else begin
                     goto(PH_IDLE);
                     if (for_reply) begin
                        hit            = 1'b1;
                        o.result_kind  = KIND_TIMEOUT;
                        o.number_value = regs.failure_value;
                     end
                  end
               end
            end
            default: begin
               case (phase)
                  PH_HASH_LEN: begin
                     frame_len = b;
                     goto(PH_HASH_CMD);
                  end
                  PH_HASH_CMD: begin
                     frame_cmd = b;
                     if (b == PAGE_CMD) begin
                        page_prev = page_now;
                        goto(PH_HASH_PAGE);
                     end else begin
                        goto(PH_IDLE);
                        hit              = 1'b1;
                        o.result_kind    = KIND_CUSTOM;
                        o.command_group  = b;
                        o.command_length = frame_len;
                     end
                  end
                  PH_HASH_PAGE: begin
                     page_now = b;
                     goto(PH_IDLE);
                     hit             = 1'b1;
                     o.result_kind   = KIND_PAGE;
                     o.page_id       = page_now;
                     o.previous_page = page_prev;
                  end
                  PH_NUM_WAIT, PH_NUM_SEARCH: begin
                     if (b == NUM_LEAD) goto(PH_NUM_DATA);
                     else if (phase == PH_NUM_WAIT) goto(PH_NUM_SEARCH);
                  end
                  PH_NUM_DATA: begin
                     acc   = acc | (32'(b) << (8 * byte_idx));
                     ticks = '0;
                     if (byte_idx == 2'd3) begin
                        byte_idx = '0;
                        term_cnt = '0;
                        goto(PH_NUM_TERM);
                     end else begin
                        byte_idx = byte_idx + 2'd1;
                     end
                  end
                  PH_NUM_TERM: begin
                     ticks = '0;
                     if (b != TERM_BYTE) begin
                        goto(PH_IDLE);
                        hit            = 1'b1;
                        o.result_kind  = KIND_FRAMING;
                        o.number_value = regs.failure_value;
                     end else if (term_cnt >= 2'd2) begin
                        goto(PH_IDLE);
                        hit            = 1'b1;
                        o.result_kind  = KIND_NUMBER;
                        o.number_value = acc;
                     end else begin
                        term_cnt = term_cnt + 2'd1;
                     end
                  end
                  PH_TXT_WAIT, PH_TXT_SEARCH: begin
                     if (b == TXT_LEAD) goto(PH_TXT_BODY);
                     else if (phase == PH_TXT_WAIT) goto(PH_TXT_SEARCH);
                  end
                  PH_TXT_BODY: begin
                     ticks = '0;
                     if (b == TERM_BYTE) begin
                        if (term_cnt >= 2'd2) begin
                           goto(PH_IDLE);
                           hit           = 1'b1;
                           o.result_kind = KIND_DONE;
                        end else begin
                           term_cnt = term_cnt + 2'd1;
                        end
                     end else begin
                        term_cnt = '0;
                        if (chars >= regs.max_text_length) begin
                           goto(PH_IDLE);
                           hit           = 1'b1;
                           o.result_kind = KIND_OVERFLOW;
                        end else begin
                           chars         = chars + 8'd1;
                           hit           = 1'b1;
                           o.result_kind = KIND_CHAR;
                           o.text_char   = b;
                        end
                     end
                  end
                  default: begin
                     if (b == HASH_BYTE) goto(PH_HASH_LEN);
                  end
               endcase
            end
         endcase
         if (hit) replies.push_back(o);
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (replies.size() == 0) begin
            report("result with none expected, kind", 32'(got.result_kind), '0);
         end else begin
            want = replies.pop_front();
            if (got.result_kind !== want.result_kind)
               report("result_kind", 32'(got.result_kind), 32'(want.result_kind));
            if (got.number_value !== want.number_value)
               report("number_value", got.number_value, want.number_value);
            if (got.text_char !== want.text_char)
               report("text_char", 32'(got.text_char), 32'(want.text_char));
            if (got.page_id !== want.page_id)
               report("page_id", 32'(got.page_id), 32'(want.page_id));
            if (got.previous_page !== want.previous_page)
               report("previous_page", 32'(got.previous_page), 32'(want.previous_page));
            if (got.command_group !== want.command_group)
               report("command_group", 32'(got.command_group), 32'(want.command_group));
            if (got.command_length !== want.command_length)
               report("command_length", 32'(got.command_length),
                      32'(want.command_length));
         end
      endtask
   endclass

   localparam int unsigned CYCLE_LIMIT = 600000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_push  = 1'b0;
   logic                   req_full;
   req_type                req_data  = '0;
   logic                   rsp_empty;
   logic                   rsp_pop   = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]            csr_wdata = '0;

   drfp_book    book;
   req_type     script[$];
   int          tick_span = 4;
   int          text_cap  = 255;
   int          pop_mode  = 0;
   int          pop_left  = 0;
   int unsigned cycles    = 0;

   display_reply_frame_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("display_reply_frame_parser regression: fail");
         $finish;
      end
   end

   // result side: check each transfer, stall in one of four randomly chosen pop modes
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) book.check_result(rsp_data);
      if (pop_left == 0) begin
         pop_mode = $urandom_range(0, 3);
         pop_left = $urandom_range(20, 300);
      end else begin
         pop_left--;
      end
      case (pop_mode)
         0:       rsp_pop <= 1'b1;
         1:       rsp_pop <= 1'($urandom_range(0, 1));
         2:       rsp_pop <= (pop_left[2:0] == 3'd0);
         default: rsp_pop <= ($urandom_range(0, 15) == 0);
      endcase
   end

   function automatic void add(op_type op, logic [7:0] b);
      req_type r;
      r.operation = op;
      r.rx_byte   = b;
      script.push_back(r);
   endfunction

   function automatic void add_ticks(int n);
      repeat (n) add(OP_TICK, 8'($urandom));
   endfunction

   function automatic void maybe_ticks();
      if ($urandom_range(0, 9) == 0) add_ticks($urandom_range(1, tick_span));
   endfunction

   function automatic logic [7:0] other_than(logic [7:0] x);
      logic [7:0] v;
      v = 8'($urandom);
      if (v == x) v = v ^ 8'h01;
      return v;
   endfunction

   function automatic void add_sequence();
      int sel;
      int n;
      int k;
      sel = $urandom_range(0, 99);
      if (sel < 28) begin
         add(OP_NUM_REQ, 8'($urandom));
         maybe_ticks();
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3))
            add(OP_BYTE, other_than(NUM_LEAD));
         add(OP_BYTE, NUM_LEAD);
         repeat (4) begin
            maybe_ticks();
            add(OP_BYTE, 8'($urandom));
         end
         k = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 3;
         for (int i = 0; i < 3; i++) begin
            maybe_ticks();
            add(OP_BYTE, (i == k) ? other_than(TERM_BYTE) : TERM_BYTE);
         end
      end else if (sel < 58) begin
         add(OP_TXT_REQ, 8'($urandom));
         maybe_ticks();
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3))
            add(OP_BYTE, other_than(TXT_LEAD));
         add(OP_BYTE, TXT_LEAD);
         if ($urandom_range(0, (text_cap <= 24) ? 3 : 11) == 0) n = text_cap + 1;
         else if (text_cap <= 24) n = $urandom_range(0, text_cap);
         else n = $urandom_range(0, 12);
         repeat (n) begin
            maybe_ticks();
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) add(OP_BYTE, TERM_BYTE);
            add(OP_BYTE, other_than(TERM_BYTE));
         end
         repeat (3) add(OP_BYTE, TERM_BYTE);
      end else if (sel < 72) begin
         add(OP_BYTE, HASH_BYTE);
         maybe_ticks();
         add(OP_BYTE, 8'($urandom));
         maybe_ticks();
         if ($urandom_range(0, 1) == 1) begin
            add(OP_BYTE, PAGE_CMD);
            maybe_ticks();
            add(OP_BYTE, 8'($urandom));
         end else begin
            add(OP_BYTE, other_than(PAGE_CMD));
         end
      end else if (sel < 82) begin
         // stall somewhere and let the ticks run out
         case ($urandom_range(0, 3))
            0: add(OP_NUM_REQ, 8'($urandom));
            1: add(OP_TXT_REQ, 8'($urandom));
            2: begin
               add(($urandom_range(0, 1) == 1) ? OP_NUM_REQ : OP_TXT_REQ, 8'($urandom));
               add(OP_BYTE, ($urandom_range(0, 1) == 1) ? NUM_LEAD : TXT_LEAD);
               repeat ($urandom_range(0, 5)) add(OP_BYTE, 8'($urandom));
            end
            default: begin
               add(OP_BYTE, HASH_BYTE);
               add(OP_BYTE, 8'($urandom));
               if ($urandom_range(0, 1) == 1) add(OP_BYTE, PAGE_CMD);
            end
         endcase
         add_ticks($urandom_range(0, tick_span));
      end else if (sel < 92) begin
         // reply cut short by a fresh request
         add(($urandom_range(0, 1) == 1) ? OP_NUM_REQ : OP_TXT_REQ, 8'($urandom));
         add(OP_BYTE, ($urandom_range(0, 1) == 1) ? NUM_LEAD : TXT_LEAD);
         repeat ($urandom_range(0, 4)) add(OP_BYTE, 8'($urandom));
         add(($urandom_range(0, 1) == 1) ? OP_NUM_REQ : OP_TXT_REQ, 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 6)) add(op_type'($urandom_range(0, 3)), 8'($urandom));
      end
   endfunction

   // push the script in bursts; halfway through, hold off until nothing is owed
   task automatic drive();
      int idx;
      int burst;
      int gap;
      int hold_at;
      bit held;
      bit go;
      idx     = 0;
      burst   = $urandom_range(1, 12);
      gap     = 0;
      hold_at = script.size() / 2;
      held    = 1'b0;
      while (idx < script.size()) begin
         @(posedge clock);
         if (req_push && !req_full) begin
            book.note_input(req_data);
            idx++;
            burst--;
            if (burst == 0) begin
               burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
               gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         if (idx < script.size() && !held && idx == hold_at) begin
            go   = 1'b0;
            held = (book.replies.size() == 0);
         end else if (gap > 0) begin
            go = 1'b0;
            gap--;
         end else begin
            go = (idx < script.size());
         end
         req_push <= go;
         if (go) req_data <= script[idx];
      end
   endtask

   task automatic settle();
      while (book.replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_setting(input cfg_type c);
      logic [31:0] vals [5];
      vals = '{32'(c.reply_timeout), 32'(c.lead_timeout), 32'(c.body_timeout),
               32'(c.max_text_length), c.failure_value};
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         do @(posedge clock); while (!(csr_valid && csr_ready));
         book.set_reg(csr_index_type'(i), vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      cfg_type c;
      int widest;
      book = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // defaults: number, text with a lone terminator dropped, page change, custom command
      add(OP_NUM_REQ, 8'h00);
      add(OP_BYTE, NUM_LEAD);
      add(OP_BYTE, 8'h00);
      add(OP_BYTE, 8'hFF);
      add(OP_BYTE, 8'h5A);
      add(OP_BYTE, 8'h80);
      repeat (3) add(OP_BYTE, TERM_BYTE);
      add(OP_TXT_REQ, 8'hFF);
      add(OP_BYTE, TXT_LEAD);
      add(OP_BYTE, 8'h41);
      add(OP_BYTE, TERM_BYTE);
      add(OP_BYTE, 8'h42);
      repeat (3) add(OP_BYTE, TERM_BYTE);
      add(OP_BYTE, HASH_BYTE);
      add(OP_BYTE, 8'h04);
      add(OP_BYTE, PAGE_CMD);
      add(OP_BYTE, 8'h07);
      add(OP_BYTE, HASH_BYTE);
      add(OP_BYTE, 8'h02);
      add(OP_BYTE, 8'h43);
      add(OP_TICK, 8'hA5);

      while (script.size() < 190) add_sequence();
      drive();
      settle();

      for (int p = 1; p < 7; p++) begin
         case (p)
            1: c = '{16'd1, 16'd1, 16'd1, 8'd1, 32'd0};
            4: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF};
            default: begin
               c.reply_timeout   = 16'($urandom_range(1, 12));
               c.lead_timeout    = 16'($urandom_range(1, 8));
               c.body_timeout    = 16'($urandom_range(1, 12));
               c.max_text_length = (p == 5) ? 8'd255 : 8'($urandom_range(1, 20));
               c.failure_value   = $urandom();
            end
         endcase
         load_setting(c);
         widest = int'(c.reply_timeout);
         if (int'(c.lead_timeout) > widest) widest = int'(c.lead_timeout);
         if (int'(c.body_timeout) > widest) widest = int'(c.body_timeout);
         tick_span = (widest <= 64) ? widest + 2 : 4;
         text_cap  = int'(c.max_text_length);
         script.delete();
         while (script.size() < 170) add_sequence();
         drive();
         settle();
      end

      if (book.replies.size() != 0)
         book.report("results never transferred, count", book.replies.size(), '0);
      if (book.errors == 0) begin
         $display("display_reply_frame_parser regression: pass");
      end else begin
         $display("display_reply_frame_parser regression: fail");
      end
      $finish;
   end

endmodule
